// ===== sv/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types and constants for the flow table byte accounting block.
// ----------------------------------------------------------------------------
package fta_pkg;

    localparam int HASH_BUCKETS = 4096;
    localparam int WAYS         = 4;
    localparam int USERS        = 2048;
    localparam int SET_W        = $clog2(HASH_BUCKETS);
    localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int USER_W       = 11;
    localparam int UIDX_W       = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int KEY_W        = 48;
    localparam int ADDR_W       = 2;

    localparam logic [31:0] HASH_MULT         = 32'd2654435761;
    localparam logic [15:0] SERVICE_PORT_INIT = 16'd5667;

    typedef enum logic [1:0] {
        CMD_BIND    = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_DESTROY = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BOUND   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOT_SVC = 3'd3,
        ST_NO_FLOW = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FLOW,
        B_USER
    } t_bstate;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [31:0] dst_ip;
        logic [15:0] dport;
        logic [63:0] orig_count;
        logic [63:0] reply_count;
        logic [10:0] user_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] owner;
        logic [63:0] delta_up;
        logic [63:0] delta_down;
        logic [63:0] total_up;
        logic [63:0] total_down;
    } t_out_item;

    // Classified job handed from the front to the back.
    typedef struct packed {
        t_cmd              cmd;
        logic              not_svc;
        logic [KEY_W-1:0]  key;
        logic [SET_W-1:0]  set_idx;
        logic [63:0]       orig_count;
        logic [63:0]       reply_count;
        logic [UIDX_W-1:0] user;
    } t_job;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [UIDX_W-1:0] owner;
        logic [63:0]       up_seen;
        logic [63:0]       down_seen;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef struct packed {
        logic [63:0] up;
        logic [63:0] down;
    } t_urow;

endpackage

// ===== sv/flow_table_byte_accounting.sv =====
// ----------------------------------------------------------------------------
// flow_table_byte_accounting
// Hashed flow table that credits connection byte counters to user totals.
// ----------------------------------------------------------------------------
// Each input beat is a bind, a counter update, an update with destroy, or a
// read of a user's totals, and each gives exactly one result beat. The front
// stage registers a beat, picks the client side against the service port
// register and hashes the client address and port to a set; a two-entry queue
// then hands the job to the back stage. The back stage takes each item in
// steps: it reads the set row of the flow memory as it pops the job, then
// searches its ways and reads the user totals row, and then writes both
// memories and loads the output register, waiting while the output stalls.
// That read-modify-write of the two single-port memories keeps the back stage
// from taking a new job before it is through with the last. After reset the
// block clears both memories, one row a cycle, and holds o_in_stall high
// meanwhile. The service port register takes writes at any time and address.
// ----------------------------------------------------------------------------
module flow_table_byte_accounting import fta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] r_service_port;
    logic        q_push, q_full;
    t_job        front_job, q_job;
    logic        q_valid, pop, clr_busy;

    // The only register decodes at every address of the small window.
    assign pready = 1'b1;
    assign prdata = {16'd0, r_service_port} | {30'd0, paddr & 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_port <= SERVICE_PORT_INIT;
        end else if (psel && penable && pwrite) begin
            r_service_port <= pwdata[15:0];
        end
    end

    fta_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_item         (i_in_data),
        .i_service_port (r_service_port),
        .i_hold         (clr_busy),
        .i_q_full       (q_full),
        .o_stall        (o_in_stall),
        .o_push         (q_push),
        .o_job          (front_job)
    );

    fta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .i_push  (q_push),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    fta_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_pop      (pop),
        .o_clr_busy (clr_busy),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_data)
    );

endmodule

// ===== sv/fta_front.sv =====
// ----------------------------------------------------------------------------
// fta_front
// Accepts input beats, picks the client side and hashes it to a set.
// ----------------------------------------------------------------------------
module fta_front import fta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    input  logic [15:0] i_service_port,
    input  logic        i_hold,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_valid, n_valid;
    t_job        r_job, n_job;
    logic [31:0] c_ip;
    logic [15:0] c_port;
    logic        c_nosvc;
    logic [47:0] c_prod;
    logic [31:0] c_hash;
    logic        accept;

    assign o_stall = i_hold || (r_valid && i_q_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_job   = r_job;

    always_comb begin
        c_nosvc = 1'b0;
        c_ip    = i_item.src_ip;
        c_port  = i_item.sport;
        if (t_cmd'(i_item.command) == CMD_UPDATE || t_cmd'(i_item.command) == CMD_DESTROY) begin
            if (i_item.dport == i_service_port) begin
                c_ip   = i_item.src_ip;
                c_port = i_item.sport;
            end else if (i_item.sport == i_service_port) begin
                c_ip   = i_item.dst_ip;
                c_port = i_item.dport;
            end else begin
                c_nosvc = 1'b1;
            end
        end
        c_prod = {32'd0, c_port} * {16'd0, HASH_MULT};
        c_hash = c_ip ^ c_prod[31:0];
        n_job.cmd         = t_cmd'(i_item.command);
        n_job.not_svc     = c_nosvc;
        n_job.key         = {c_ip, c_port};
        n_job.set_idx     = c_hash[SET_W-1:0];
        n_job.orig_count  = i_item.orig_count;
        n_job.reply_count = i_item.reply_count;
        n_job.user        = i_item.user_index[UIDX_W-1:0];
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== sv/fta_queue.sv =====
// ----------------------------------------------------------------------------
// fta_queue
// Two-entry queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module fta_queue import fta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_push,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== sv/fta_back.sv =====
// ----------------------------------------------------------------------------
// fta_back
// Executes jobs against the flow set memory and the user totals memory.
// ----------------------------------------------------------------------------
module fta_back import fta_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_pop,
    output logic      o_clr_busy,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_row  mem_set  [HASH_BUCKETS];
    t_urow mem_user [USERS];

    t_bstate r_state, n_state;
    t_job    r_job;
    t_row    r_row;
    t_urow   r_urow;
    logic    r_hit, n_hit;
    logic [WAY_W-1:0] r_hitw, n_hitw, n_freew;
    logic    r_free, n_free;
    logic [WAY_W-1:0] r_freew;
    logic [UIDX_W-1:0] r_u, n_u;
    logic    r_clr_busy;
    logic [SET_W-1:0] r_clr;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      load_out, user_rd;

    logic              set_we, user_we;
    logic [SET_W-1:0]  set_wa;
    t_row              set_wd, upd_row;
    logic [UIDX_W-1:0] user_wa;
    t_urow             user_wd, upd_urow;
    logic [63:0]       du, dd;
    logic              is_update;

    assign o_clr_busy = r_clr_busy;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;
    assign o_pop      = (r_state == B_IDLE) && i_q_valid && !r_clr_busy;
    assign is_update  = (r_job.cmd == CMD_UPDATE) || (r_job.cmd == CMD_DESTROY);

    always_comb begin
        n_hit   = 1'b0;
        n_hitw  = '0;
        n_free  = 1'b0;
        n_freew = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_row[w].valid && r_row[w].key == r_job.key) begin
                n_hit  = 1'b1;
                n_hitw = WAY_W'(w);
            end
            if (!r_row[w].valid) begin
                n_free  = 1'b1;
                n_freew = WAY_W'(w);
            end
        end
        n_u = r_job.user;
        if (n_hit && (r_job.cmd != CMD_READ)) begin
            n_u = r_row[n_hitw].owner;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        load_out    = 1'b0;
        user_rd     = 1'b0;
        du          = r_job.orig_count - r_row[r_hitw].up_seen;
        dd          = r_job.reply_count - r_row[r_hitw].down_seen;
        upd_row     = r_row;
        upd_urow.up   = r_urow.up + du;
        upd_urow.down = r_urow.down + dd;
        set_we  = 1'b0;
        set_wa  = r_job.set_idx;
        set_wd  = r_row;
        user_we = 1'b0;
        user_wa = r_u;
        user_wd = upd_urow;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_state = B_FLOW;
                end
            end
            B_FLOW: begin
                user_rd = 1'b1;
                n_state = B_USER;
            end
            B_USER: begin
                if (!r_out_valid || !i_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                    n_out.status     = ST_OK;
                    n_out.owner      = USER_W'(r_u);
                    n_out.delta_up   = '0;
                    n_out.delta_down = '0;
                    n_out.total_up   = r_urow.up;
                    n_out.total_down = r_urow.down;
                    if (r_job.cmd == CMD_BIND) begin
                        if (r_hit) begin
                            n_out.status = ST_BOUND;
                        end else if (r_free) begin
                            upd_row[r_freew].valid     = 1'b1;
                            upd_row[r_freew].key       = r_job.key;
                            upd_row[r_freew].owner     = r_job.user;
                            upd_row[r_freew].up_seen   = '0;
                            upd_row[r_freew].down_seen = '0;
                            set_we = 1'b1;
                            set_wd = upd_row;
                        end else begin
                            n_out.status = ST_FULL;
                        end
                    end else if (is_update) begin
                        if (r_job.not_svc || !r_hit) begin
                            n_out        = '0;
                            n_out.status = r_job.not_svc ? ST_NOT_SVC : ST_NO_FLOW;
                        end else begin
                            upd_row[r_hitw].up_seen   = r_job.orig_count;
                            upd_row[r_hitw].down_seen = r_job.reply_count;
                            upd_row[r_hitw].valid     = (r_job.cmd != CMD_DESTROY);
                            set_we  = 1'b1;
                            set_wd  = upd_row;
                            user_we = 1'b1;
                            n_out.delta_up   = du;
                            n_out.delta_down = dd;
                            n_out.total_up   = upd_urow.up;
                            n_out.total_down = upd_urow.down;
                        end
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
        if (r_clr_busy) begin
            set_we  = 1'b1;
            set_wa  = r_clr;
            set_wd  = '0;
            user_we = ({1'b0, r_clr} < (SET_W + 1)'(USERS));
            user_wa = UIDX_W'(r_clr);
            user_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_clr_busy) begin
                r_clr <= r_clr + SET_W'(1);
                if (r_clr == SET_W'(HASH_BUCKETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
            r_row <= mem_set[i_q_job.set_idx];
        end
        if (r_state == B_FLOW) begin
            r_hit   <= n_hit;
            r_hitw  <= n_hitw;
            r_free  <= n_free;
            r_freew <= n_freew;
            r_u     <= n_u;
        end
        if (user_rd) begin
            r_urow <= mem_user[n_u];
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_we) begin
            mem_set[set_wa] <= set_wd;
        end
        if (user_we) begin
            mem_user[user_wa] <= user_wd;
        end
    end

endmodule

// ===== sv/fta_checker.sv =====
// ----------------------------------------------------------------------------
// fta_checker
// Port-level checks on the result channel of the flow table block.
// ----------------------------------------------------------------------------
module fta_checker import fta_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_NO_FLOW)
        else $error("result status out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NOT_SVC || o_out_data.status == ST_NO_FLOW)
        |-> o_out_data.owner == '0 && o_out_data.total_up == '0
            && o_out_data.total_down == '0 && o_out_data.delta_up == '0)
        else $error("miss result carries nonzero fields");

    a_bind_nodelta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_BOUND || o_out_data.status == ST_FULL)
        |-> o_out_data.delta_up == '0 && o_out_data.delta_down == '0)
        else $error("bind result credits bytes");

endmodule

bind flow_table_byte_accounting fta_checker u_fta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
